>>> hw/rtl/epq_pkg.sv
// shared types and constants of the event priority queue
package epq_pkg;

    localparam int CAPACITY = 1024;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int OCC_W    = 11;

    typedef enum logic [1:0] {
        MODE_ENQ = 2'd0,
        MODE_DEQ = 2'd1,
        MODE_DEL = 2'd2,
        MODE_NOP = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_EMPTY    = 3'd1,
        ST_FULL     = 3'd2,
        ST_DUP      = 3'd3,
        ST_NOTFOUND = 3'd4
    } status_t;

    typedef struct packed {
        logic [63:0] ts;
        logic [31:0] snd;
        logic [31:0] dst;
        logic [31:0] id;
    } key_t;

    typedef struct packed {
        key_t        key;
        logic [15:0] hnd;
    } entry_t;

    // operation broadcast to all cells
    typedef struct packed {
        logic   ins;     // insert key
        logic   del;     // remove entry at first match/position
        logic   deq;     // remove head
        entry_t ent;
    } bcast_t;

    // per-cell compare flags
    typedef struct packed {
        logic gt;    // stored key greater than given key
        logic eq;
    } cmp_t;

endpackage

>>> hw/rtl/epq_cell.sv
// one slot of the sorted chain: holds an entry and shifts with neighbors
module epq_cell (
    input  logic            aclk,
    input  logic            occ,        // slot holds a valid entry
    input  logic            cmp_en,     // compare phase
    input  logic            upd_en,     // update phase
    input  epq_pkg::bcast_t op,
    input  epq_pkg::entry_t left_ent,   // entry of lower neighbor
    input  epq_pkg::entry_t right_ent,  // entry of upper neighbor
    input  logic            left_shift, // lower neighbor gt flag (insert)
    output epq_pkg::entry_t ent,
    output epq_pkg::cmp_t   cmp,
    output logic            hit_out     // this slot matched
);
    import epq_pkg::*;

    entry_t ent_reg;
    cmp_t   cmp_reg;
    logic   gt_c, eq_c;

    assign gt_c = (ent_reg.key > op.ent.key);
    assign eq_c = (ent_reg.key == op.ent.key);
    assign ent  = ent_reg;
    assign cmp  = cmp_reg;
    assign hit_out = occ & cmp_reg.eq;

    always_ff @(posedge aclk) begin
        if (cmp_en) begin
            cmp_reg.gt <= gt_c | ~occ;
            cmp_reg.eq <= eq_c & occ;
        end
        if (upd_en) begin
            if (op.ins) begin
                if (cmp_reg.gt) begin
                    ent_reg <= left_shift ? left_ent : op.ent;
                end
            end else if (op.deq) begin
                ent_reg <= right_ent;
            end else if (op.del) begin
                // keys are sorted and unique: every slot at or above the match shifts down
                if (cmp_reg.gt | cmp_reg.eq) begin
                    ent_reg <= right_ent;
                end
            end
        end
    end
endmodule

>>> hw/rtl/event_priority_queue_top.sv
// top level of the event priority queue built from a chain of cells
// The queue keeps up to CAPACITY (1024) events sorted in a chain of cells,
// lowest key in cell zero. An accepted item passes a compare phase, in which
// all cells compare their entry against the given key in parallel, and then
// an update phase, in which each cell takes its own, its lower or upper
// neighbor's entry, or the new one; the result item is valid from the cycle
// after the update phase. The result sits in an output register and the next
// item is accepted only once the result has been taken, so the queue does not
// take a new item before it is through with the last one. Duplicate and
// not-found checks or-reduce the cells' match flags in the update phase; a
// delete shifts every cell at or above the matching key. min_timestamp comes
// straight from cell zero, or is all ones when the queue is empty.
module event_priority_queue_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_mode,
    input  logic [63:0] s_timestamp,
    input  logic [31:0] s_sender_lp,
    input  logic [31:0] s_dest_lp,
    input  logic [31:0] s_event_ident,
    input  logic [15:0] s_event_handle,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_status,
    output logic [63:0] m_out_timestamp,
    output logic [31:0] m_out_sender_lp,
    output logic [31:0] m_out_dest_lp,
    output logic [31:0] m_out_event_ident,
    output logic [15:0] m_out_handle,
    output logic [10:0] m_occupancy,
    output logic [10:0] m_peak_occupancy,
    output logic [63:0] m_min_timestamp
);
    import epq_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_CMP  = 3'b010,
        S_UPD  = 3'b100
    } state_t;

    state_t state_reg, state_next;
    logic [CNT_W-1:0] count_reg, peak_reg;
    mode_t  mode_reg;
    entry_t in_reg;
    bcast_t op;

    entry_t ents   [CAPACITY];
    cmp_t   cmps   [CAPACITY];
    logic [CAPACITY-1:0] hits;
    logic   occs   [CAPACITY];

    // result registers
    logic        m_valid_reg;
    status_t     status_reg;
    entry_t      rm_reg;
    logic [CNT_W-1:0] cnt_new;

    assign s_ready = (state_reg == S_IDLE) & ~m_valid_reg;
    assign m_valid = m_valid_reg;

    // decisions during update phase from the count and the compare flags
    logic full, empty, dup, found;
    logic [CNT_W-1:0] cnt_cap;
    assign cnt_cap = CNT_W'(CAPACITY);
    assign full  = (count_reg >= cnt_cap);
    assign empty = (count_reg == '0);
    assign dup   = |hits;
    assign found = |hits;

    // removed entry for delete: at most one cell matches
    entry_t del_ent;
    always_comb begin
        del_ent = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            del_ent = del_ent | (ents[i] & {$bits(entry_t){hits[i]}});
        end
    end

    always_comb begin
        op.ent = in_reg;
        op.ins = (mode_reg == MODE_ENQ) & ~full & ~dup;
        op.deq = (mode_reg == MODE_DEQ) & ~empty;
        op.del = (mode_reg == MODE_DEL) & found;
    end

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            assign occs[g] = (CNT_W'(g) < count_reg);
            epq_cell u_cell (
                .aclk      (aclk),
                .occ       (occs[g]),
                .cmp_en    (state_reg == S_CMP),
                .upd_en    (state_reg == S_UPD),
                .op        (op),
                .left_ent  ((g == 0) ? in_reg : ents[(g == 0) ? 0 : g - 1]),
                .right_ent ((g == CAPACITY - 1) ? in_reg :
                            ents[(g == CAPACITY - 1) ? g : g + 1]),
                .left_shift((g == 0) ? 1'b0 : cmps[(g == 0) ? 0 : g - 1].gt),
                .ent       (ents[g]),
                .cmp       (cmps[g]),
                .hit_out   (hits[g])
            );
        end
    endgenerate

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (s_valid && s_ready) state_next = S_CMP;
            S_CMP:  state_next = S_UPD;
            S_UPD:  state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        cnt_new = count_reg;
        if (op.ins) cnt_new = count_reg + 1'b1;
        else if (op.deq || op.del) cnt_new = count_reg - 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            mode_reg <= mode_t'(s_mode);
            in_reg   <= '{key: '{ts: s_timestamp, snd: s_sender_lp,
                                  dst: s_dest_lp, id: s_event_ident},
                          hnd: s_event_handle};
        end
        if (state_reg == S_UPD) begin
            rm_reg <= op.deq ? ents[0] : (op.del ? del_ent : '0);
            priority if (mode_reg == MODE_ENQ) begin
                status_reg <= full ? ST_FULL : (dup ? ST_DUP : ST_OK);
            end else if (mode_reg == MODE_DEQ) begin
                status_reg <= empty ? ST_EMPTY : ST_OK;
            end else if (mode_reg == MODE_DEL) begin
                status_reg <= found ? ST_OK : ST_NOTFOUND;
            end else begin
                status_reg <= ST_OK;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            peak_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == S_UPD) begin
                count_reg   <= cnt_new;
                if (cnt_new > peak_reg) peak_reg <= cnt_new;
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_status          = status_reg;
    assign m_out_timestamp   = rm_reg.key.ts;
    assign m_out_sender_lp   = rm_reg.key.snd;
    assign m_out_dest_lp     = rm_reg.key.dst;
    assign m_out_event_ident = rm_reg.key.id;
    assign m_out_handle      = rm_reg.hnd;
    assign m_occupancy       = OCC_W'(count_reg);
    assign m_peak_occupancy  = OCC_W'(peak_reg);
    assign m_min_timestamp   = (count_reg == '0) ? '1 : ents[0].key.ts;

    // checks
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= cnt_cap) else $error("count above capacity");
    a_peak: assert property (@(posedge aclk) disable iff (!aresetn)
        peak_reg >= count_reg) else $error("peak below count");
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != S_IDLE) |-> !s_ready) else $error("accept while busy");
    a_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_UPD) |=> m_valid_reg) else $error("result missing");
endmodule

>>> tb/event_priority_queue_top_test.sv
// self-checking testbench of the event priority queue top level
`timescale 1ns / 1ps

module event_priority_queue_top_test;
    import epq_pkg::*;

    // one result item as the queue reports it
    typedef struct {
        status_t     status;
        entry_t      removed;
        logic [10:0] occ;
        logic [10:0] peak;
        logic [63:0] min_ts;
    } queue_result_t;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [1:0]  s_mode;
    logic [63:0] s_timestamp;
    logic [31:0] s_sender_lp;
    logic [31:0] s_dest_lp;
    logic [31:0] s_event_ident;
    logic [15:0] s_event_handle;
    logic        m_valid;
    logic        m_ready;
    logic [2:0]  m_status;
    logic [63:0] m_out_timestamp;
    logic [31:0] m_out_sender_lp;
    logic [31:0] m_out_dest_lp;
    logic [31:0] m_out_event_ident;
    logic [15:0] m_out_handle;
    logic [10:0] m_occupancy;
    logic [10:0] m_peak_occupancy;
    logic [63:0] m_min_timestamp;

    // sorted copy of the queue contents and the peak count it keeps
    entry_t        sorted_events[$];
    int            model_peak;
    // results still owed by the block, oldest first
    queue_result_t owed_results[$];

    int  sender_idle_pct;
    int  recv_stall_pct;
    bit  recv_hold;
    int  error_count;
    int  items_sent;
    int  results_seen;
    int  cycle_count;
    int  full_hits;
    int  dup_hits;
    int  del_hits;

    localparam int CYCLE_LIMIT = 600000;

    event_priority_queue_top u_dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_mode            (s_mode),
        .s_timestamp       (s_timestamp),
        .s_sender_lp       (s_sender_lp),
        .s_dest_lp         (s_dest_lp),
        .s_event_ident     (s_event_ident),
        .s_event_handle    (s_event_handle),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_status          (m_status),
        .m_out_timestamp   (m_out_timestamp),
        .m_out_sender_lp   (m_out_sender_lp),
        .m_out_dest_lp     (m_out_dest_lp),
        .m_out_event_ident (m_out_event_ident),
        .m_out_handle      (m_out_handle),
        .m_occupancy       (m_occupancy),
        .m_peak_occupancy  (m_peak_occupancy),
        .m_min_timestamp   (m_min_timestamp)
    );

    // 10 ns clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // run-time guard
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("Some tests failed");
            $finish;
        end
    end

    // apply one queue operation to the sorted copy and return what it reports
    function automatic queue_result_t apply_queue_op(mode_t op, entry_t ent);
        queue_result_t r;
        int pos;
        bit hit;
        r.status  = ST_OK;
        r.removed = '0;
        hit = 1'b0;
        pos = sorted_events.size();
        case (op)
            MODE_ENQ: begin
                if (sorted_events.size() >= CAPACITY) begin
                    r.status = ST_FULL;
                end else begin
                    // whole key compared as one unsigned vector gives the lexicographic order
                    foreach (sorted_events[i]) begin
                        if (sorted_events[i].key == ent.key) begin
                            hit = 1'b1;
                            break;
                        end
                        if (sorted_events[i].key > ent.key) begin
                            pos = i;
                            break;
                        end
                    end
                    if (hit) begin
                        r.status = ST_DUP;
                    end else begin
                        sorted_events.insert(pos, ent);
                        if (sorted_events.size() > model_peak) model_peak = sorted_events.size();
                    end
                end
            end
            MODE_DEQ: begin
                if (sorted_events.size() == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    r.removed = sorted_events.pop_front();
                end
            end
            MODE_DEL: begin
                // handle is not part of the match
                foreach (sorted_events[i]) begin
                    if (sorted_events[i].key == ent.key) begin
                        hit = 1'b1;
                        pos = i;
                        break;
                    end
                end
                if (!hit) begin
                    r.status = ST_NOTFOUND;
                end else begin
                    r.removed = sorted_events[pos];
                    sorted_events.delete(pos);
                end
            end
            default: ;
        endcase
        r.occ    = 11'(sorted_events.size());
        r.peak   = 11'(model_peak);
        r.min_ts = (sorted_events.size() != 0) ? sorted_events[0].key.ts : '1;
        return r;
    endfunction

    // every accepted input item produces one expected result
    always @(posedge aclk) begin
        entry_t        ent;
        queue_result_t r;
        if (aresetn && s_valid && s_ready) begin
            ent.key.ts  = s_timestamp;
            ent.key.snd = s_sender_lp;
            ent.key.dst = s_dest_lp;
            ent.key.id  = s_event_ident;
            ent.hnd     = s_event_handle;
            r = apply_queue_op(mode_t'(s_mode), ent);
            if (r.status == ST_FULL) full_hits++;
            if (r.status == ST_DUP) dup_hits++;
            if (mode_t'(s_mode) == MODE_DEL && r.status == ST_OK) del_hits++;
            owed_results.push_back(r);
            items_sent++;
        end
    end

    function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            $display("%0t: mismatch on %s: expected %h, got %h", $realtime, name, want, got);
            error_count++;
        end
    endfunction

    // compare each result item with the oldest expectation
    always @(posedge aclk) begin
        queue_result_t r;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (owed_results.size() == 0) begin
                $display("%0t: result item with nothing expected, status %0d",
                         $realtime, m_status);
                error_count++;
            end else begin
                r = owed_results.pop_front();
                check_field("status", 64'(r.status), 64'(m_status));
                check_field("out_timestamp", r.removed.key.ts, m_out_timestamp);
                check_field("out_sender_lp", 64'(r.removed.key.snd), 64'(m_out_sender_lp));
                check_field("out_dest_lp", 64'(r.removed.key.dst), 64'(m_out_dest_lp));
                check_field("out_event_ident", 64'(r.removed.key.id),
                            64'(m_out_event_ident));
                check_field("out_handle", 64'(r.removed.hnd), 64'(m_out_handle));
                check_field("occupancy", 64'(r.occ), 64'(m_occupancy));
                check_field("peak_occupancy", 64'(r.peak), 64'(m_peak_occupancy));
                check_field("min_timestamp", r.min_ts, m_min_timestamp);
            end
        end
    end

    // receiver: random stalls, or a long hold-off while recv_hold is set
    always @(negedge aclk) begin
        if (recv_hold) m_ready <= 1'b0;
        else m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // send one item; called at a falling edge, returns at a falling edge
    task automatic send_item(mode_t op, logic [63:0] ts, logic [31:0] snd,
                             logic [31:0] dst, logic [31:0] id, logic [15:0] hnd);
        bit taken;
        // random gap before the item; valid only drops when a gap is taken
        if ($urandom_range(99) < sender_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
            while ($urandom_range(99) < sender_idle_pct) @(negedge aclk);
        end
        s_valid        <= 1'b1;
        s_mode         <= op;
        s_timestamp    <= ts;
        s_sender_lp    <= snd;
        s_dest_lp      <= dst;
        s_event_ident  <= id;
        s_event_handle <= hnd;
        taken = 1'b0;
        while (!taken) begin
            @(posedge aclk);
            taken = s_ready;
        end
        @(negedge aclk);
    endtask

    task automatic send_entry(mode_t op, entry_t e);
        send_item(op, e.key.ts, e.key.snd, e.key.dst, e.key.id, e.hnd);
    endtask

    // sender pause until every owed result has come back
    task automatic wait_drained();
        s_valid <= 1'b0;
        @(negedge aclk);
        while (owed_results.size() != 0) @(negedge aclk);
    endtask

    // random key: mostly from a narrow pool so duplicates and matches happen
    function automatic entry_t random_entry();
        entry_t e;
        if ($urandom_range(9) == 0) begin
            e.key.ts  = {$urandom, $urandom};
            e.key.snd = $urandom;
            e.key.dst = $urandom;
            e.key.id  = $urandom;
        end else begin
            e.key.ts  = ($urandom_range(1) != 0) ? 64'h3FF0_0000_0000_0000 + $urandom_range(15)
                                                 : 64'hFFFF_FFFF_FFFF_FFF0 + $urandom_range(15);
            e.key.snd = ($urandom_range(1) != 0) ? $urandom_range(3) : 32'hFFFF_FFFC + $urandom_range(3);
            e.key.dst = $urandom_range(1) ? $urandom_range(1) : 32'hFFFF_FFFF;
            e.key.id  = ($urandom_range(3) == 0) ? $urandom : $urandom_range(3);
        end
        e.hnd = 16'($urandom);
        return e;
    endfunction

    task automatic test_directed();
        entry_t lo, hi, mid;
        lo  = '0;
        hi  = '1;
        mid = '0;
        mid.key.ts = 64'h4000_0000_0000_0000;
        mid.hnd    = 16'h5A5A;
        send_entry(MODE_DEQ, lo);             // dequeue when empty
        send_entry(MODE_DEL, mid);            // delete when empty
        send_entry(MODE_NOP, hi);             // unused mode value
        send_entry(MODE_ENQ, hi);             // largest key and handle
        send_entry(MODE_ENQ, lo);             // smallest key
        send_entry(MODE_ENQ, mid);
        send_entry(MODE_ENQ, hi);             // fully equal key
        mid.hnd = 16'hA5A5;
        send_entry(MODE_ENQ, mid);            // same key, other handle: still duplicate
        mid.key.id = 32'd1;
        send_entry(MODE_ENQ, mid);            // differs in last key field only
        mid.key.id = 32'd0;
        mid.key.dst = 32'd1;
        send_entry(MODE_ENQ, mid);            // differs in destination only
        mid.key.dst = 32'd0;
        mid.key.snd = 32'd1;
        send_entry(MODE_ENQ, mid);            // differs in sender only
        mid.key.snd = 32'd0;
        mid.hnd = 16'h1234;
        send_entry(MODE_DEL, mid);            // delete ignores handle
        send_entry(MODE_DEL, mid);            // now absent
        send_entry(MODE_NOP, lo);
        send_entry(MODE_DEQ, lo);
        send_entry(MODE_DEL, hi);
        send_entry(MODE_DEQ, lo);
        send_entry(MODE_DEQ, lo);
        send_entry(MODE_DEQ, lo);
        send_entry(MODE_DEQ, lo);             // empty again
        wait_drained();
    endtask

    // fill to capacity, hit the full case, then drain about half of it by dequeues and random deletions
    task automatic test_full_queue();
        entry_t e;
        for (int i = 0; i <= CAPACITY; i++) begin
            e = random_entry();
            e.key.ts = {$urandom, $urandom};
            send_entry(MODE_ENQ, e);
        end
        e = random_entry();
        send_entry(MODE_ENQ, e);
        while (sorted_events.size() > CAPACITY / 2) begin
            if ($urandom_range(3) == 0)
                send_entry(MODE_DEL, sorted_events[$urandom_range(sorted_events.size() - 1)]);
            else
                send_entry(MODE_DEQ, e);
        end
        wait_drained();
    endtask

    // receiver holds off for a long stretch while the sender keeps offering
    task automatic test_holdoff();
        fork
            begin
                recv_hold = 1'b1;
                repeat (300) @(posedge aclk);
                recv_hold = 1'b0;
            end
            begin
                for (int i = 0; i < 20; i++) send_entry(MODE_ENQ, random_entry());
            end
        join
        wait_drained();
    endtask

    task automatic test_random_mix(int n_items);
        entry_t e;
        int pick;
        for (int i = 0; i < n_items; i++) begin
            e = random_entry();
            pick = $urandom_range(99);
            if (pick < 45) begin
                send_entry(MODE_ENQ, e);
            end else if (pick < 70) begin
                send_entry(MODE_DEQ, e);
            end else if (pick < 95) begin
                // half the deletions name a queued event, with a random handle
                if ($urandom_range(1) != 0 && sorted_events.size() != 0) begin
                    e.key = sorted_events[$urandom_range(sorted_events.size() - 1)].key;
                end
                send_entry(MODE_DEL, e);
            end else begin
                send_entry(MODE_NOP, e);
            end
        end
    endtask

    task automatic test_random_phases();
        int idle_set[4];
        int stall_set[4];
        idle_set  = '{0, 54, 0, 38};
        stall_set = '{0, 0, 54, 38};
        for (int p = 0; p < 4; p++) begin
            sender_idle_pct = idle_set[p];
            recv_stall_pct  = stall_set[p];
            test_random_mix(100);
        end
        sender_idle_pct = 0;
        recv_stall_pct  = 0;
        wait_drained();
    endtask

    initial begin
        aresetn         = 1'b0;
        s_valid         = 1'b0;
        s_mode          = MODE_NOP;
        s_timestamp     = '0;
        s_sender_lp     = '0;
        s_dest_lp       = '0;
        s_event_ident   = '0;
        s_event_handle  = '0;
        m_ready         = 1'b0;
        recv_hold       = 1'b0;
        sender_idle_pct = 0;
        recv_stall_pct  = 0;
        error_count     = 0;
        items_sent      = 0;
        results_seen    = 0;
        cycle_count     = 0;
        full_hits       = 0;
        dup_hits        = 0;
        del_hits        = 0;
        model_peak      = 0;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        test_directed();
        test_holdoff();
        sender_idle_pct = 20;
        recv_stall_pct  = 20;
        test_full_queue();
        test_random_phases();

        // let any late result show up as unexpected
        repeat (20) @(negedge aclk);
        if (owed_results.size() != 0) begin
            $display("%0d expected results never arrived", owed_results.size());
            error_count++;
        end
        $display("covered %0d items / %0d results: full %0d, duplicate %0d, deletions %0d",
                 items_sent, results_seen, full_hits, dup_hits, del_hits);
        $display("peak occupancy %0d, with sender gaps, receiver stalls and a long hold-off",
                 model_peak);
        if (error_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

>>> files.f
hw/rtl/epq_pkg.sv
hw/rtl/epq_cell.sv
hw/rtl/event_priority_queue_top.sv
tb/event_priority_queue_top_test.sv
